>>> rtl/core/hwmm_pkg.sv
// ----------------------------------------------------------------------------
// hwmm_pkg
// Types and constants shared by the heightmap window min/max block.
// ----------------------------------------------------------------------------
package hwmm_pkg;

  localparam int unsigned MAX_SIDE_DEF = 512;

  // fixed field widths
  localparam int unsigned SIDE_W   = 10;
  localparam int unsigned COORD_W  = 9;
  localparam int unsigned GROW_W   = 10;  // grown corner, holds high + 1
  localparam int unsigned INDEX_W  = 18;
  localparam int unsigned HEIGHT_W = 16;

  localparam logic [SIDE_W-1:0]   SIDE_RESET = SIDE_W'(512);
  localparam logic [SIDE_W-1:0]   SIDE_MIN   = SIDE_W'(2);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = '0;

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [INDEX_W-1:0]  cell_index;
    logic [HEIGHT_W-1:0] new_height;
    logic [COORD_W-1:0]  low_x;
    logic [COORD_W-1:0]  low_z;
    logic [COORD_W-1:0]  high_x;
    logic [COORD_W-1:0]  high_z;
  } in_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] min_height;
    logic [HEIGHT_W-1:0] max_height;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/heightmap_window_min_max.sv
// ----------------------------------------------------------------------------
// heightmap_window_min_max
// A write request stores one 16-bit height sample in a single-port height
// memory of MAX_SIDE x MAX_SIDE entries; the block is ready again in the next
// cycle. A query request grows the patch by one texel on each side, clamps it
// to the map, and walks the window one texel per cycle through the memory read
// port, folding each sample into a running min and max. A query holds the input
// stalled from acceptance through the setup, scan, drain and done states until
// its result is loaded; an empty window skips the scan and drain states. The
// result sits in an output register, so a new request is taken while the
// previous result waits to be read.
// ----------------------------------------------------------------------------
module heightmap_window_min_max #(
  parameter int unsigned MAX_SIDE = hwmm_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hwmm_pkg::SIDE_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hwmm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hwmm_pkg::out_item_t            out_data
);

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = hwmm_pkg::SIDE_W;
  localparam int unsigned GW    = hwmm_pkg::GROW_W;
  localparam int unsigned HW    = hwmm_pkg::HEIGHT_W;

  hwmm_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] side_r;
  logic [SW-1:0] side_eff;
  logic [SW-1:0] side_m1;

  logic [GW-1:0] x0_r, x0_nxt, z0_r, z0_nxt;
  logic [GW-1:0] x1_r, x1_nxt, z1_r, z1_nxt;
  logic [GW-1:0] x_r, x_nxt, z_r, z_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [HW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [HW-1:0] rd_data_r;

  logic [HW-1:0] height_store [DEPTH];

  logic                in_accept;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                out_load;
  logic                out_free;
  logic                win_empty;
  logic                row_end;
  logic                last_texel;
  logic [2*SW-1:0]     row_prod;
  logic [GW-1:0]       lx_grow, lz_grow, hx_grow, hz_grow;
  logic                out_valid_r, out_valid_nxt;
  hwmm_pkg::out_item_t out_data_r;

  // effective side: at least 2, at most MAX_SIDE
  always_comb begin
    side_eff = side_r;
    if (side_r < hwmm_pkg::SIDE_MIN) begin
      side_eff = hwmm_pkg::SIDE_MIN;
    end else if (32'(side_r) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end
    side_m1 = side_eff - SW'(1);
  end

  // window growth on the incoming corners
  always_comb begin
    lx_grow = (in_data.low_x == '0) ? '0 : GW'(in_data.low_x) - GW'(1);
    lz_grow = (in_data.low_z == '0) ? '0 : GW'(in_data.low_z) - GW'(1);
    hx_grow = GW'(in_data.high_x) + GW'(1);
    hz_grow = GW'(in_data.high_z) + GW'(1);
    if (hx_grow > GW'(side_m1)) hx_grow = GW'(side_m1);
    if (hz_grow > GW'(side_m1)) hz_grow = GW'(side_m1);
  end

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign win_empty  = (x0_r > x1_r) || (z0_r > z1_r);
  assign row_end    = (x_r == x1_r);
  assign last_texel = row_end && (z_r == z1_r);
  assign row_prod   = (2*SW)'(z0_r[SW-1:0]) * (2*SW)'(side_eff);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hwmm_pkg::ST_IDLE: begin
        if (in_accept && in_data.kind == hwmm_pkg::KIND_QUERY) begin
          state_nxt = hwmm_pkg::ST_SETUP;
        end
      end
      hwmm_pkg::ST_SETUP: begin
        state_nxt = win_empty ? hwmm_pkg::ST_DONE : hwmm_pkg::ST_SCAN;
      end
      hwmm_pkg::ST_SCAN: begin
        if (last_texel) state_nxt = hwmm_pkg::ST_DRAIN;
      end
      hwmm_pkg::ST_DRAIN: begin
        state_nxt = hwmm_pkg::ST_DONE;
      end
      hwmm_pkg::ST_DONE: begin
        if (out_free) state_nxt = hwmm_pkg::ST_IDLE;
      end
      default: state_nxt = hwmm_pkg::ST_IDLE;
    endcase
  end

  // state decoded controls
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      hwmm_pkg::ST_IDLE:  in_stall = 1'b0;
      hwmm_pkg::ST_SETUP: ;
      hwmm_pkg::ST_SCAN:  rd_en = 1'b1;
      hwmm_pkg::ST_DRAIN: ;
      hwmm_pkg::ST_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  assign wr_en   = in_accept && (in_data.kind == hwmm_pkg::KIND_WRITE) &&
                   (32'(in_data.cell_index) < DEPTH);
  assign wr_addr = AW'(in_data.cell_index);
  assign rd_addr = base_r + AW'(x_r);

  // window walk and min/max fold
  always_comb begin
    x0_nxt      = x0_r;
    z0_nxt      = z0_r;
    x1_nxt      = x1_r;
    z1_nxt      = z1_r;
    x_nxt       = x_r;
    z_nxt       = z_r;
    base_nxt    = base_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    rd_pend_nxt = rd_en;

    if (state_r == hwmm_pkg::ST_IDLE && in_accept) begin
      x0_nxt = lx_grow;
      z0_nxt = lz_grow;
      x1_nxt = hx_grow;
      z1_nxt = hz_grow;
    end

    if (state_r == hwmm_pkg::ST_SETUP) begin
      base_nxt = AW'(row_prod);
      x_nxt    = x0_r;
      z_nxt    = z0_r;
      lo_nxt   = hwmm_pkg::HEIGHT_MAX;
      hi_nxt   = hwmm_pkg::HEIGHT_MIN;
    end

    if (state_r == hwmm_pkg::ST_SCAN && !last_texel) begin
      if (row_end) begin
        x_nxt    = x0_r;
        z_nxt    = z_r + GW'(1);
        base_nxt = base_r + AW'(side_eff);
      end else begin
        x_nxt = x_r + GW'(1);
      end
    end

    // sample read in the previous cycle
    if (rd_pend_r) begin
      if (rd_data_r < lo_r) lo_nxt = rd_data_r;
      if (rd_data_r > hi_r) hi_nxt = rd_data_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hwmm_pkg::ST_IDLE;
      side_r      <= hwmm_pkg::SIDE_RESET;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) side_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x0_r   <= x0_nxt;
    z0_r   <= z0_nxt;
    x1_r   <= x1_nxt;
    z1_r   <= z1_nxt;
    x_r    <= x_nxt;
    z_r    <= z_nxt;
    base_r <= base_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    if (out_load) begin
      out_data_r.min_height <= lo_r;
      out_data_r.max_height <= hi_r;
    end
  end

  // height memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) height_store[wr_addr] <= in_data.new_height;
    if (rd_en) rd_data_r <= height_store[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/hwmm_checker.sv
// ----------------------------------------------------------------------------
// hwmm_checker
// Port-level checks for the heightmap window min/max block.
// ----------------------------------------------------------------------------
module hwmm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input hwmm_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input hwmm_pkg::out_item_t         out_data
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // a write request completes in its own cycle
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == hwmm_pkg::KIND_WRITE |=> !in_stall)
    else $error("write request left the block busy");

  // a query request always occupies the block for at least setup
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == hwmm_pkg::KIND_QUERY |=> in_stall)
    else $error("query request did not start a window walk");

  // min above max only for the empty-window answer
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.min_height <= out_data.max_height) ||
                  (out_data.min_height == hwmm_pkg::HEIGHT_MAX &&
                   out_data.max_height == hwmm_pkg::HEIGHT_MIN))
    else $error("min above max on a non-empty window");

endmodule

bind heightmap_window_min_max hwmm_checker u_hwmm_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for heightmap_window_min_max. A queue-fed driver sends
// height writes and window queries with random gaps. A clocked monitor keeps
// its own copy of the height map and the side length, works out each query's
// min/max when the request is taken, and checks every result in order while
// the result side stalls at random. Runs over several side lengths.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STORE_CELLS   = hwmm_pkg::MAX_SIDE_DEF * hwmm_pkg::MAX_SIDE_DEF;
  localparam int unsigned PRELOAD_CELLS = 1024;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_LIMIT   = 400_000;
  localparam int unsigned CYCLE_LIMIT   = 6_000_000;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [hwmm_pkg::SIDE_W-1:0] cfg_wdata = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  hwmm_pkg::in_item_t          in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  hwmm_pkg::out_item_t         out_data;

  heightmap_window_min_max dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pending requests and the bounds they are expected to produce
  hwmm_pkg::in_item_t  pending_reqs[$];
  hwmm_pkg::out_item_t expected_bounds[$];

  // monitor-side map and side length
  logic [hwmm_pkg::HEIGHT_W-1:0] height_mem [0:STORE_CELLS-1];
  logic [hwmm_pkg::SIDE_W-1:0]   side_reg = hwmm_pkg::SIDE_RESET;

  // generator-side view: which cells hold a sample so far
  bit          written_cells [0:STORE_CELLS-1];
  int unsigned gen_side  = hwmm_pkg::MAX_SIDE_DEF;
  int unsigned gen_count = 0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          req_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          preload_mode = 1'b0;
  int unsigned req_gap = 0;
  int unsigned res_hold = 0;
  int unsigned req_stretch = 0;
  int unsigned res_stretch = 0;
  bit          req_calm = 1'b0;
  bit          res_calm = 1'b0;

  function automatic int unsigned side_in_use(logic [hwmm_pkg::SIDE_W-1:0] v);
    if (v < hwmm_pkg::SIDE_MIN) return 32'(hwmm_pkg::SIDE_MIN);
    if (32'(v) > hwmm_pkg::MAX_SIDE_DEF) return hwmm_pkg::MAX_SIDE_DEF;
    return 32'(v);
  endfunction

  function automatic int unsigned lower_edge(logic [hwmm_pkg::COORD_W-1:0] c);
    return (c == '0) ? 0 : 32'(c) - 1;
  endfunction

  function automatic int unsigned upper_edge(logic [hwmm_pkg::COORD_W-1:0] c,
                                             int unsigned s);
    int unsigned h;
    h = 32'(c) + 1;
    return (h > s - 1) ? s - 1 : h;
  endfunction

  function automatic hwmm_pkg::out_item_t window_bounds(hwmm_pkg::in_item_t q);
    hwmm_pkg::out_item_t           r;
    int unsigned                   s, x0, x1, z0, z1;
    logic [hwmm_pkg::HEIGHT_W-1:0] v;
    r.min_height = hwmm_pkg::HEIGHT_MAX;
    r.max_height = hwmm_pkg::HEIGHT_MIN;
    s  = side_in_use(side_reg);
    x0 = lower_edge(q.low_x);
    z0 = lower_edge(q.low_z);
    x1 = upper_edge(q.high_x, s);
    z1 = upper_edge(q.high_z, s);
    if (x0 <= x1 && z0 <= z1) begin
      for (int unsigned z = z0; z <= z1; z++) begin
        for (int unsigned x = x0; x <= x1; x++) begin
          v = height_mem[z * s + x];
          if (v < r.min_height) r.min_height = v;
          if (v > r.max_height) r.max_height = v;
        end
      end
    end
    return r;
  endfunction

  // runs of back-to-back traffic mixed with runs of random waits
  function automatic int unsigned draw_wait(inout int unsigned stretch, inout bit calm);
    if (stretch == 0) begin
      calm    = ($urandom_range(0, 3) == 0);
      stretch = $urandom_range(20, 60);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [hwmm_pkg::HEIGHT_W-1:0] any_height();
    case ($urandom_range(0, 9))
      0:       return hwmm_pkg::HEIGHT_MIN;
      1:       return hwmm_pkg::HEIGHT_MAX;
      default: return hwmm_pkg::HEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic push_write(int unsigned idx, logic [hwmm_pkg::HEIGHT_W-1:0] h);
    hwmm_pkg::in_item_t it;
    it.kind       = hwmm_pkg::KIND_WRITE;
    it.cell_index = hwmm_pkg::INDEX_W'(idx);
    it.new_height = h;
    it.low_x      = hwmm_pkg::COORD_W'($urandom);
    it.low_z      = hwmm_pkg::COORD_W'($urandom);
    it.high_x     = hwmm_pkg::COORD_W'($urandom);
    it.high_z     = hwmm_pkg::COORD_W'($urandom);
    pending_reqs.push_back(it);
    written_cells[idx] = 1'b1;
    gen_count++;
  endtask

  // any cell the window touches that was never written gets a write first
  task automatic push_query(int unsigned lx, int unsigned lz, int unsigned hx,
                            int unsigned hz);
    hwmm_pkg::in_item_t it;
    int unsigned        x0, x1, z0, z1;
    x0 = lower_edge(hwmm_pkg::COORD_W'(lx));
    z0 = lower_edge(hwmm_pkg::COORD_W'(lz));
    x1 = upper_edge(hwmm_pkg::COORD_W'(hx), gen_side);
    z1 = upper_edge(hwmm_pkg::COORD_W'(hz), gen_side);
    if (x0 <= x1 && z0 <= z1) begin
      for (int unsigned z = z0; z <= z1; z++) begin
        for (int unsigned x = x0; x <= x1; x++) begin
          if (!written_cells[z * gen_side + x]) push_write(z * gen_side + x, any_height());
        end
      end
    end
    it.kind       = hwmm_pkg::KIND_QUERY;
    it.cell_index = hwmm_pkg::INDEX_W'($urandom);
    it.new_height = hwmm_pkg::HEIGHT_W'($urandom);
    it.low_x      = hwmm_pkg::COORD_W'(lx);
    it.low_z      = hwmm_pkg::COORD_W'(lz);
    it.high_x     = hwmm_pkg::COORD_W'(hx);
    it.high_z     = hwmm_pkg::COORD_W'(hz);
    pending_reqs.push_back(it);
    gen_count++;
  endtask

  task automatic push_patch(int unsigned lx, int unsigned lz);
    int unsigned hx, hz;
    hx = lx + $urandom_range(0, 9);
    hz = lz + $urandom_range(0, 9);
    push_query(lx, lz, (hx > 511) ? 511 : hx, (hz > 511) ? 511 : hz);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned start, rows, lx, lz, hx, hz;
    start = gen_count;
    rows  = PRELOAD_CELLS / gen_side;
    if (rows > gen_side) rows = gen_side;
    while (gen_count - start < n) begin
      case ($urandom_range(0, 39)) inside
        [0:5]: push_write($urandom_range(0, STORE_CELLS - 1), any_height());
        [6:9]: begin
          // empty window: low corner past high corner, or past the map edge
          if ($urandom_range(0, 1) || gen_side >= 511) begin
            lx = $urandom_range(3, 511);
            hx = $urandom_range(0, lx - 3);
          end else begin
            lx = $urandom_range(gen_side + 1, 511);
            hx = $urandom_range(0, 511);
          end
          lz = $urandom_range(0, 511);
          hz = $urandom_range(0, 511);
          if ($urandom_range(0, 1)) push_query(lz, lx, hz, hx);
          else push_query(lx, lz, hx, hz);
        end
        10: begin
          // small maps are fully preloaded, so any corners are safe
          if (gen_side * gen_side <= PRELOAD_CELLS) begin
            push_query($urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom_range(0, 511), $urandom_range(0, 511));
          end else begin
            push_patch($urandom_range(0, gen_side - 1), $urandom_range(0, gen_side - 1));
          end
        end
        [32:39]:
          push_patch($urandom_range(0, gen_side - 1), $urandom_range(0, gen_side - 1));
        default: push_patch($urandom_range(0, gen_side - 1), $urandom_range(0, rows - 1));
      endcase
    end
  endtask

  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    while ((pending_reqs.size() != 0 || in_valid || expected_bounds.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(logic [hwmm_pkg::SIDE_W-1:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gen_side = side_in_use(v);
  endtask

  // request driver
  always @(negedge clk) begin : req_driver
    bit                 drive;
    hwmm_pkg::in_item_t nxt;
    if (rst_n) begin
      drive = in_valid;
      nxt   = in_data;
      if (req_taken) begin
        drive     = 1'b0;
        req_gap   = preload_mode ? 0 : draw_wait(req_stretch, req_calm);
        req_taken = 1'b0;
      end
      if (!drive) begin
        if (req_gap != 0) begin
          req_gap--;
        end else if (pending_reqs.size() != 0) begin
          nxt   = pending_reqs.pop_front();
          drive = 1'b1;
        end
      end
      in_valid <= drive;
      in_data  <= nxt;
    end
  end

  // result side stall
  always @(negedge clk) begin : res_sink
    if (rst_n) begin
      if (res_taken) begin
        res_hold  = draw_wait(res_stretch, res_calm);
        res_taken = 1'b0;
      end
      out_stall <= (res_hold != 0);
      if (out_valid && res_hold != 0) res_hold--;
    end
  end

  always @(posedge clk) begin : monitor
    hwmm_pkg::out_item_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        if (cfg_we) side_reg = cfg_wdata;
        if (in_valid && !in_stall) begin
          req_taken = 1'b1;
          if (in_data.kind == hwmm_pkg::KIND_WRITE) begin
            height_mem[in_data.cell_index] = in_data.new_height;
          end else begin
            expected_bounds.push_back(window_bounds(in_data));
          end
        end
        if (out_valid && !out_stall) begin
          res_taken = 1'b1;
          if (expected_bounds.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
          end else begin
            want = expected_bounds.pop_front();
            if (out_data.min_height !== want.min_height) begin
              error_count++;
              $display("%0t: min_height mismatch: expected %h, actual %h",
                       $time, want.min_height, out_data.min_height);
            end
            if (out_data.max_height !== want.max_height) begin
              error_count++;
              $display("%0t: max_height mismatch: expected %h, actual %h",
                       $time, want.max_height, out_data.max_height);
            end
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [hwmm_pkg::SIDE_W-1:0] side_plan [13];
    side_plan = '{10'd2, 10'd0, 10'd1, 10'd7, 10'd100, 10'd512, 10'd1023,
                  10'd600, 10'd128, 10'd511, 10'd3, 10'd2, 10'd2};
    side_plan[11] = hwmm_pkg::SIDE_W'($urandom_range(2, 512));
    side_plan[12] = hwmm_pkg::SIDE_W'($urandom_range(2, 512));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the low end of the store back to back
    preload_mode = 1'b1;
    for (int unsigned i = 0; i < PRELOAD_CELLS; i++) push_write(i, any_height());
    wait_idle();
    preload_mode = 1'b0;

    // directed, at the reset side length
    push_write(0, hwmm_pkg::HEIGHT_MIN);
    push_write(STORE_CELLS - 1, hwmm_pkg::HEIGHT_MAX);
    push_write(513, hwmm_pkg::HEIGHT_MAX);
    push_query(0, 0, 0, 0);
    push_query(511, 511, 511, 511);
    push_query(0, 0, 511, 0);
    push_query(12, 3, 5, 4);
    push_query(3, 20, 9, 2);
    push_query(509, 0, 511, 1);
    random_phase(PHASE_ITEMS);

    foreach (side_plan[i]) begin
      wait_idle();
      write_side(side_plan[i]);
      if (gen_side * gen_side <= PRELOAD_CELLS) begin
        push_query(0, 0, 511, 511);
        push_query(gen_side + 1, 0, 511, 1);
      end
      random_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (expected_bounds.size() != 0) begin
      error_count++;
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, expected_bounds.size());
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> heightmap_window_min_max.f
rtl/core/hwmm_pkg.sv
rtl/core/heightmap_window_min_max.sv
rtl/core/hwmm_checker.sv
tb/sv/tb_top.sv
